// ----- rtl/core/mer_pkg.sv -----
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by mer_ctrl, mer_dpath and midpoint_ellipse_rasterizer; no dependencies.
package mer_pkg;

  localparam int MER_COORD_BITS  = 12;
  localparam int MER_RADIUS_BITS = 10;

  localparam logic [1:0] EMIT_LAST = 2'd3;

  typedef enum logic [1:0] {
    RG_IDLE,
    RG_ONE,
    RG_TWO,
    RG_FIN
  } region_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_A4,
    ST_AB,
    ST_P1,
    ST_INIT1,
    ST_BSQ,
    ST_BMUL,
    ST_BCMP,
    ST_MUL1,
    ST_MUL2,
    ST_UPD1,
    ST_UPD2,
    ST_P2,
    ST_INIT2,
    ST_CHK2,
    ST_EMIT,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    MUL_HOLD,
    MUL_AA,
    MUL_BB,
    MUL_A4,
    MUL_AB,
    MUL_BTA,
    MUL_ATB,
    MUL_CAND,
    MUL_CSUM,
    MUL_FIRST,
    MUL_SECOND
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SAVE_ASQ,
    OP_SAVE_BSQ,
    OP_SAVE_A4,
    OP_SAVE_AB,
    OP_INIT1,
    OP_BIT_TEST,
    OP_SAVE_HOLD,
    OP_UPD1,
    OP_UPD2,
    OP_INIT2,
    OP_EMIT,
    OP_EMIT_DONE
  } dp_op_t;

  typedef struct packed {
    logic       latch;
    mul_sel_t   mul_sel;
    dp_op_t     op;
    logic       reg_one;
    logic [1:0] emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic r1_go;
    logic r2_go;
    logic p_pos;
    logic last_bit;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/mer_ctrl.sv -----
// Sequencer for the midpoint ellipse rasterizer: state, region and emit count.
// Depends on mer_pkg; drives mer_dpath through dp_cmd_t, reads dp_stat_t.
module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_stall,
  input  mer_pkg::dp_stat_t stat,
  output mer_pkg::dp_cmd_t  cmd
);
  import mer_pkg::*;

  ctl_state_t state_r, state_nxt;
  region_t    region_r, region_nxt;
  logic [1:0] k_r, k_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      region_r <= RG_IDLE;
      k_r      <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      region_r <= region_nxt;
      k_r      <= k_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    region_nxt   = region_r;
    k_nxt        = k_r;
    cmd.latch    = 1'b0;
    cmd.mul_sel  = MUL_HOLD;
    cmd.op       = OP_NONE;
    cmd.reg_one  = (region_r == RG_ONE);
    cmd.emit_idx = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_func) begin
            cmd.latch = 1'b1;
            state_nxt = ST_SQA;
          end else begin
            case (region_r)
              RG_ONE:  state_nxt = stat.r1_go ? ST_MUL1 : ST_P2;
              RG_TWO: begin
                if (stat.r2_go) begin
                  state_nxt = ST_MUL1;
                end else begin
                  region_nxt = RG_FIN;
                  state_nxt  = ST_DONE;
                end
              end
              default: state_nxt = ST_DONE;
            endcase
          end
        end
      end
      ST_SQA: begin
        cmd.mul_sel = MUL_AA;
        state_nxt   = ST_SQB;
      end
      ST_SQB: begin
        cmd.op      = OP_SAVE_ASQ;
        cmd.mul_sel = MUL_BB;
        state_nxt   = ST_A4;
      end
      ST_A4: begin
        cmd.op      = OP_SAVE_BSQ;
        cmd.mul_sel = MUL_A4;
        state_nxt   = ST_AB;
      end
      ST_AB: begin
        cmd.op      = OP_SAVE_A4;
        cmd.mul_sel = MUL_AB;
        state_nxt   = ST_P1;
      end
      ST_P1: begin
        cmd.op      = OP_SAVE_AB;
        cmd.mul_sel = MUL_BTA;
        state_nxt   = ST_INIT1;
      end
      ST_INIT1: begin
        cmd.op     = OP_INIT1;
        region_nxt = RG_ONE;
        state_nxt  = ST_BSQ;
      end
      ST_BSQ: begin
        cmd.mul_sel = MUL_CAND;
        state_nxt   = ST_BMUL;
      end
      ST_BMUL: begin
        cmd.mul_sel = MUL_CSUM;
        state_nxt   = ST_BCMP;
      end
      ST_BCMP: begin
        cmd.op = OP_BIT_TEST;
        if (stat.last_bit) begin
          k_nxt     = 2'd0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_BSQ;
        end
      end
      ST_MUL1: begin
        cmd.mul_sel = MUL_FIRST;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op      = OP_SAVE_HOLD;
        cmd.mul_sel = MUL_SECOND;
        state_nxt   = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.op    = OP_UPD1;
        state_nxt = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.op    = OP_UPD2;
        k_nxt     = 2'd0;
        state_nxt = ST_EMIT;
      end
      ST_P2: begin
        cmd.mul_sel = MUL_ATB;
        state_nxt   = ST_INIT2;
      end
      ST_INIT2: begin
        cmd.op     = OP_INIT2;
        region_nxt = RG_TWO;
        state_nxt  = ST_CHK2;
      end
      ST_CHK2: begin
        if (stat.r2_go) begin
          state_nxt = ST_MUL1;
        end else begin
          region_nxt = RG_FIN;
          state_nxt  = ST_DONE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT;
          k_nxt  = k_r + 2'd1;
          if (k_r == EMIT_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_DONE;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/mer_dpath.sv -----
// Datapath: latched start fields, shared multiplier, decision, offsets,
// boundary search and the output register. Depends on mer_pkg.
module mer_dpath #(
  parameter int COORD_BITS  = mer_pkg::MER_COORD_BITS,
  parameter int RADIUS_BITS = mer_pkg::MER_RADIUS_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mer_pkg::dp_cmd_t               cmd,
  output mer_pkg::dp_stat_t              stat,
  input  logic [COORD_BITS-1:0]          in_center_x,
  input  logic [COORD_BITS-1:0]          in_center_y,
  input  logic [RADIUS_BITS-1:0]         in_radius_a,
  input  logic [RADIUS_BITS-1:0]         in_radius_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_BITS+1:0]   out_point_x,
  output logic signed [COORD_BITS+1:0]   out_point_y,
  output logic                           out_point_valid,
  output logic                           out_last,
  output logic                           out_done_res
);
  import mer_pkg::*;

  localparam int R   = RADIUS_BITS;
  localparam int SQW = 2 * R;          // squared radius
  localparam int MW  = 2 * R + 2;      // multiplier operand
  localparam int PRW = 2 * MW;         // product
  localparam int HW  = 3 * R;          // radius^2 * offset
  localparam int DW  = 4 * R + 8;      // decision, never wraps
  localparam int PW  = COORD_BITS + 2; // point
  localparam int EW  = PW + R;
  localparam int BW  = $clog2(R);

  logic [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [R-1:0]          a_r, a_nxt, b_r, b_nxt;
  logic [SQW-1:0]        asq_r, asq_nxt, bsq_r, bsq_nxt;
  logic [2*SQW-1:0]      a4_r, a4_nxt, ab_r, ab_nxt;
  logic [PRW-1:0]        prod_r, prod_nxt;
  logic [HW-1:0]         hold_r, hold_nxt;
  logic signed [DW-1:0]  dec_r, dec_nxt;
  logic [R-1:0]          x_r, x_nxt, y_r, y_nxt, x0_r, x0_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [PW-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic                  pv_r, pv_nxt, last_r, last_nxt, done_r, done_nxt;

  logic [MW-1:0]         mul_a, mul_b;
  logic [MW-1:0]         ta2, tb2;
  logic [SQW:0]          sq_sum;
  logic [R-1:0]          cand;
  logic [SQW-1:0]        sq1, sq2;
  logic signed [DW-1:0]  sq2_x12;
  logic [EW-1:0]         xp, xm, yp, ym;
  logic                  out_free;

  // (2r-1)^2 = 4r^2 - 4r + 1, kept nonnegative (r = 0 gives 1)
  assign ta2    = (MW'(asq_r) << 2) + MW'(1) - (MW'(a_r) << 2);
  assign tb2    = (MW'(bsq_r) << 2) + MW'(1) - (MW'(b_r) << 2);
  assign sq_sum = (SQW+1)'(asq_r) + (SQW+1)'(bsq_r);
  assign sq1    = cmd.reg_one ? bsq_r : asq_r;
  assign sq2    = cmd.reg_one ? asq_r : bsq_r;
  assign sq2_x12 = ($signed(DW'(sq2)) <<< 3) + ($signed(DW'(sq2)) <<< 2);

  always_comb begin
    cand        = x0_r;
    cand[bit_r] = 1'b1;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_AA:     begin mul_a = MW'(a_r);    mul_b = MW'(a_r);    end
      MUL_BB:     begin mul_a = MW'(b_r);    mul_b = MW'(b_r);    end
      MUL_A4:     begin mul_a = MW'(asq_r);  mul_b = MW'(asq_r);  end
      MUL_AB:     begin mul_a = MW'(asq_r);  mul_b = MW'(bsq_r);  end
      MUL_BTA:    begin mul_a = MW'(bsq_r);  mul_b = ta2;         end
      MUL_ATB:    begin mul_a = MW'(asq_r);  mul_b = tb2;         end
      MUL_CAND:   begin mul_a = MW'(cand);   mul_b = MW'(cand);   end
      MUL_CSUM:   begin mul_a = MW'(prod_r[SQW-1:0]); mul_b = MW'(sq_sum); end
      MUL_FIRST: begin
        mul_a = cmd.reg_one ? MW'(bsq_r) : MW'(asq_r);
        mul_b = cmd.reg_one ? MW'(x_r)   : MW'(y_r);
      end
      MUL_SECOND: begin
        mul_a = cmd.reg_one ? MW'(asq_r) : MW'(bsq_r);
        mul_b = cmd.reg_one ? MW'(y_r)   : MW'(x_r);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // mirrored points; wrap to the point width
  assign xp = EW'(cx_r) + EW'(x_r);
  assign xm = EW'(cx_r) - EW'(x_r);
  assign yp = EW'(cy_r) + EW'(y_r);
  assign ym = EW'(cy_r) - EW'(y_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    asq_nxt  = asq_r;
    bsq_nxt  = bsq_r;
    a4_nxt   = a4_r;
    ab_nxt   = ab_r;
    hold_nxt = hold_r;
    dec_nxt  = dec_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    x0_nxt   = x0_r;
    bit_nxt  = bit_r;
    prod_nxt = (cmd.mul_sel == MUL_HOLD) ? prod_r : mul_a * mul_b;
    px_nxt   = px_r;
    py_nxt   = py_r;
    pv_nxt   = pv_r;
    last_nxt = last_r;
    done_nxt = done_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.latch) begin
      cx_nxt = in_center_x;
      cy_nxt = in_center_y;
      a_nxt  = in_radius_a;
      b_nxt  = in_radius_b;
    end

    case (cmd.op)
      OP_SAVE_ASQ:  asq_nxt = prod_r[SQW-1:0];
      OP_SAVE_BSQ:  bsq_nxt = prod_r[SQW-1:0];
      OP_SAVE_A4:   a4_nxt  = prod_r[2*SQW-1:0];
      OP_SAVE_AB:   ab_nxt  = prod_r[2*SQW-1:0];
      OP_SAVE_HOLD: hold_nxt = prod_r[HW-1:0];
      OP_INIT1: begin
        dec_nxt = $signed(DW'(prod_r))
                - (($signed(DW'(ab_r)) - $signed(DW'(asq_r))) <<< 2);
        x_nxt   = a_r;
        y_nxt   = '0;
        x0_nxt  = '0;
        bit_nxt = BW'(R - 1);
      end
      OP_BIT_TEST: begin
        if ((sq_sum != '0) && (prod_r <= PRW'(a4_r))) begin
          x0_nxt = cand;
        end
        bit_nxt = bit_r - BW'(1);
      end
      OP_UPD1: begin
        if (stat.p_pos) begin
          dec_nxt = dec_r + ($signed(DW'(sq1)) <<< 3) - ($signed(DW'(hold_r)) <<< 3);
          if (cmd.reg_one) begin
            if (x_r != '0) x_nxt = x_r - R'(1);
          end else begin
            if (y_r != '0) y_nxt = y_r - R'(1);
          end
        end
      end
      OP_UPD2: begin
        dec_nxt = dec_r + sq2_x12 + ($signed(DW'(prod_r[HW-1:0])) <<< 3);
        if (cmd.reg_one) y_nxt = y_r + R'(1);
        else             x_nxt = x_r + R'(1);
      end
      OP_INIT2: begin
        dec_nxt = $signed(DW'(prod_r))
                - (($signed(DW'(ab_r)) - $signed(DW'(bsq_r))) <<< 2);
        x_nxt   = '0;
        y_nxt   = b_r;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        px_nxt   = cmd.emit_idx[0] ? $signed(xm[PW-1:0]) : $signed(xp[PW-1:0]);
        py_nxt   = cmd.emit_idx[1] ? $signed(ym[PW-1:0]) : $signed(yp[PW-1:0]);
        pv_nxt   = 1'b1;
        last_nxt = (cmd.emit_idx == EMIT_LAST);
        done_nxt = 1'b0;
      end
      OP_EMIT_DONE: begin
        out_valid_nxt = 1'b1;
        px_nxt   = '0;
        py_nxt   = '0;
        pv_nxt   = 1'b0;
        last_nxt = 1'b1;
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    asq_r  <= asq_nxt;
    bsq_r  <= bsq_nxt;
    a4_r   <= a4_nxt;
    ab_r   <= ab_nxt;
    prod_r <= prod_nxt;
    hold_r <= hold_nxt;
    dec_r  <= dec_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    x0_r   <= x0_nxt;
    bit_r  <= bit_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    pv_r   <= pv_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign stat.r1_go    = (x_r >= x0_r) && (y_r != {R{1'b1}});
  assign stat.r2_go    = (x_r < x0_r);
  assign stat.p_pos    = !dec_r[DW-1] && (dec_r != '0);
  assign stat.last_bit = (bit_r == '0);
  assign stat.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_valid = pv_r;
  assign out_last        = last_r;
  assign out_done_res    = done_r;

endmodule

// ----- rtl/core/midpoint_ellipse_rasterizer.sv -----
// Top level of the midpoint ellipse rasterizer.
// Depends on mer_pkg, mer_ctrl and mer_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall): in_func = 0 starts a new ellipse from
//   in_center_x/y and in_radius_a/b, in_func = 1 advances one midpoint step.
//   Output channel (out_valid / out_stall): each transfer carries one result.
//   A start gives the four mirrored points of (a,0); a step gives four points,
//   or one result with out_done_res = 1 once both regions are finished.
//   out_last marks the final result of each input transfer.
// Sequence (states from input transfer to the first result on out_valid):
//   start: ST_SQA, ST_SQB, ST_A4, ST_AB, ST_P1, ST_INIT1. Squares and the
//     decision seed go through the one shared multiplier; the boundary search
//     then runs ST_BSQ, ST_BMUL and ST_BCMP for each radius bit.
//   step: ST_MUL1, ST_MUL2, ST_UPD1, ST_UPD2 in a region, led by ST_P2,
//     ST_INIT2, ST_CHK2 on entering region two; ST_DONE for a done result.
//   The four points leave at one per cycle unless a stall holds them; the
//   next input transfer is taken the cycle after the last result is loaded.
//   The shared multiplier and the single sequencer set the pace.
// Reset: rst_n (synchronous, active low) returns to idle with no ellipse
//   loaded; a step then gives a done result.
// Stall: a stalled result holds in the output register and the sequencer
//   waits; in_stall stays high until all results of the item are loaded.
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = mer_pkg::MER_COORD_BITS,
  parameter int RADIUS_BITS = mer_pkg::MER_RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [COORD_BITS-1:0]         in_center_x,
  input  logic [COORD_BITS-1:0]         in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_a,
  input  logic [RADIUS_BITS-1:0]        in_radius_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS+1:0]  out_point_x,
  output logic signed [COORD_BITS+1:0]  out_point_y,
  output logic                          out_point_valid,
  output logic                          out_last,
  output logic                          out_done_res
);
  import mer_pkg::*;

  dp_cmd_t  cmd;   // sequencer -> datapath
  dp_stat_t stat;  // datapath -> sequencer

  // Sequencer: owns the state, the region and the emit index.
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: multiplier, decision, offsets, boundary and output register.
  mer_dpath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius_a     (in_radius_a),
    .in_radius_b     (in_radius_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_valid (out_point_valid),
    .out_last        (out_last),
    .out_done_res    (out_done_res)
  );

endmodule

// ----- dv/tb_midpoint_ellipse_rasterizer.sv -----
// Self-checking testbench for midpoint_ellipse_rasterizer: random input gaps and output
// stall, in-bench midpoint predictor, in-order scoreboard. Depends on mer_pkg and the RTL.
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer;
  import mer_pkg::*;

  localparam int CB = MER_COORD_BITS;
  localparam int RB = MER_RADIUS_BITS;
  localparam int RADIUS_TOP = (1 << RB) - 1;

  // Input item codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam int IDLE_PCT     = 17;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 40;
  localparam int CALM_FIRST   = 3000;  // no idling on either side inside this window
  localparam int CALM_LAST    = 7000;

  typedef struct packed {
    logic          func;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [RB-1:0] ra;
    logic [RB-1:0] rb;
  } in_item_t;

  typedef struct packed {
    logic signed [CB+1:0] px;
    logic signed [CB+1:0] py;
    logic                 pv;
    logic                 last;
    logic                 done;
  } point_res_t;

  // Walker state; shown is set when the last transfer produced four points
  typedef struct packed {
    region_t            region;
    logic [RB-1:0]      ox;
    logic [RB-1:0]      oy;
    logic signed [63:0] p;
    logic [RB-1:0]      x0;
    logic [2*RB-1:0]    asq;
    logic [2*RB-1:0]    bsq;
    logic [CB-1:0]      cx;
    logic [CB-1:0]      cy;
    logic [RB-1:0]      rb;
    logic               shown;
  } ellipse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_func = FUNC_STEP;
  logic [CB-1:0] in_center_x = '0;
  logic [CB-1:0] in_center_y = '0;
  logic [RB-1:0] in_radius_a = '0;
  logic [RB-1:0] in_radius_b = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CB+1:0] out_point_x;
  logic signed [CB+1:0] out_point_y;
  logic                 out_point_valid;
  logic                 out_last;
  logic                 out_done_res;

  in_item_t   pending_items[$];
  point_res_t points_due[$];
  ellipse_t   plan_st;   // used while building the stimulus
  ellipse_t   track_st;  // advanced on every accepted input transfer
  int         mismatch_count = 0;
  int         cyc = 0;
  int         quiet_cycles = 0;

  midpoint_ellipse_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_a    (in_radius_a),
    .in_radius_b    (in_radius_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_valid(out_point_valid),
    .out_last       (out_last),
    .out_done_res   (out_done_res)
  );

  always #1 clk = ~clk;

  // One midpoint iteration (or a restart). P is carried in 64 bits so it never wraps.
  function automatic ellipse_t ellipse_advance(ellipse_t s, logic func, logic [CB-1:0] cx,
                                               logic [CB-1:0] cy, logic [RB-1:0] ra,
                                               logic [RB-1:0] rb);
    ellipse_t n;
    longint   la, a_sq, b_sq, t, ox, oy, rbl;
    longint   sum, a4, cand;
    n = s;
    n.shown = 1'b0;
    if (func == FUNC_START) begin
      la = ra;
      rbl = rb;
      a_sq = la * la;
      b_sq = rbl * rbl;
      n.cx = cx;
      n.cy = cy;
      n.rb = rb;
      n.asq = a_sq[2*RB-1:0];
      n.bsq = b_sq[2*RB-1:0];
      // x0: largest x with x*x*(a^2+b^2) <= a^4, bit by bit from the top
      sum = a_sq + b_sq;
      a4 = a_sq * a_sq;
      n.x0 = '0;
      if (sum != 0) begin
        for (int bit_i = RB - 1; bit_i >= 0; bit_i--) begin
          cand = n.x0 | (1 << bit_i);
          if (cand * cand * sum <= a4) n.x0 = cand[RB-1:0];
        end
      end
      n.ox = ra;
      n.oy = '0;
      t = 2 * la - 1;
      n.p = b_sq * t * t - 4 * a_sq * (b_sq - 1);
      n.region = RG_ONE;
      n.shown = 1'b1;
    end else begin
      a_sq = n.asq;
      b_sq = n.bsq;
      if (n.region == RG_ONE) begin
        if (n.ox >= n.x0 && n.oy < RADIUS_TOP) begin
          ox = n.ox;
          oy = n.oy;
          if (n.p > 0) begin
            n.p = n.p + b_sq * (8 - 8 * ox);
            if (n.ox > 0) n.ox = n.ox - 1'b1;  // clamps at zero
          end
          n.p = n.p + a_sq * (12 + 8 * oy);
          n.oy = n.oy + 1'b1;
          n.shown = 1'b1;
        end else begin
          rbl = n.rb;
          t = 2 * rbl - 1;
          n.ox = '0;
          n.oy = n.rb;
          n.p = a_sq * t * t - 4 * b_sq * (a_sq - 1);
          n.region = RG_TWO;
        end
      end
      if (n.region == RG_TWO && !n.shown) begin
        if (n.ox < n.x0) begin
          ox = n.ox;
          oy = n.oy;
          if (n.p > 0) begin
            n.p = n.p + a_sq * (8 - 8 * oy);
            if (n.oy > 0) n.oy = n.oy - 1'b1;
          end
          n.p = n.p + b_sq * (12 + 8 * ox);
          n.ox = n.ox + 1'b1;
          n.shown = 1'b1;
        end else begin
          n.region = RG_FIN;
        end
      end
    end
    return n;
  endfunction

  // Four mirrored points in fixed order, or the lone done result
  task automatic queue_points(input ellipse_t s);
    point_res_t r;
    int         xs[4];
    int         ys[4];
    int         cxi, cyi, oxi, oyi;
    if (s.shown) begin
      cxi = s.cx;
      cyi = s.cy;
      oxi = s.ox;
      oyi = s.oy;
      xs[0] = cxi + oxi;  ys[0] = cyi + oyi;
      xs[1] = cxi - oxi;  ys[1] = cyi + oyi;
      xs[2] = cxi + oxi;  ys[2] = cyi - oyi;
      xs[3] = cxi - oxi;  ys[3] = cyi - oyi;
      for (int k = 0; k < 4; k++) begin
        r.px = xs[k][CB+1:0];
        r.py = ys[k][CB+1:0];
        r.pv = 1'b1;
        r.last = (k == 3);
        r.done = 1'b0;
        points_due.push_back(r);
      end
    end else begin
      r.px = '0;
      r.py = '0;
      r.pv = 1'b0;
      r.last = 1'b1;
      r.done = 1'b1;
      points_due.push_back(r);
    end
  endtask

  task automatic add_item(input logic f, input int cx, input int cy, input int ra, input int rb);
    in_item_t it;
    it.func = f;
    it.cx = cx[CB-1:0];
    it.cy = cy[CB-1:0];
    it.ra = ra[RB-1:0];
    it.rb = rb[RB-1:0];
    pending_items.push_back(it);
    plan_st = ellipse_advance(plan_st, it.func, it.cx, it.cy, it.ra, it.rb);
  endtask

  // Steps carry junk in the ignored fields
  task automatic add_step();
    add_item(FUNC_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // Step until the walk reports done (or cap steps), then a few steps past the end
  task automatic walk_ellipse(input int cap, input int extra);
    int k;
    k = 0;
    while (k < cap) begin
      add_step();
      k++;
      if (!plan_st.shown) k = cap;
    end
    repeat (extra) add_step();
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  wire calm = (cyc >= CALM_FIRST && cyc < CALM_LAST);

  // Driver: present the next pending item once the previous one has transferred;
  // the predictor runs on the transfer itself.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_st = ellipse_advance(track_st, in_func, in_center_x, in_center_y,
                                   in_radius_a, in_radius_b);
        queue_points(track_st);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid    <= 1'b1;
          in_func     <= pending_items[0].func;
          in_center_x <= pending_items[0].cx;
          in_center_y <= pending_items[0].cy;
          in_radius_a <= pending_items[0].ra;
          in_radius_b <= pending_items[0].rb;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, in-order compare, watchdog on transfer activity
  always @(posedge clk) begin
    point_res_t e;
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $display("%0t: unexpected result, actual x=%0d y=%0d pv=%b last=%b done=%b",
                   $time, out_point_x, out_point_y, out_point_valid, out_last, out_done_res);
          mismatch_count++;
        end else begin
          e = points_due.pop_front();
          check_field("point_x", e.px, out_point_x);
          check_field("point_y", e.py, out_point_y);
          check_field("point_valid", e.pv, out_point_valid);
          check_field("last", e.last, out_last);
          check_field("done_res", e.done, out_done_res);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_midpoint_ellipse_rasterizer: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus build, reset, and end of run
  initial begin
    int base, pick, ra, rb;
    plan_st = '0;
    plan_st.region = RG_IDLE;
    track_st = plan_st;

    // Directed: step with nothing loaded
    add_step();
    // Largest centre and radii, then two steps
    add_item(FUNC_START, 4095, 4095, 1023, 1023);
    add_step();
    add_step();
    // Flat ellipse at the origin: negative coordinates
    add_item(FUNC_START, 0, 0, 1023, 1);
    add_step();
    add_step();
    // Both radii zero
    add_item(FUNC_START, 0, 4095, 0, 0);
    add_step();
    add_step();
    // Small ellipse walked through both regions, then steps once finished
    add_item(FUNC_START, 2048, 1365, 3, 2);
    walk_ellipse(20, 2);

    // Tall thin ellipse: x0 is 0, so region one keeps stepping once x has
    // reached zero and the x decrement clamps there
    add_item(FUNC_START, $urandom_range(0, 4095), $urandom_range(0, 4095), 1,
             $urandom_range(2, 8));
    walk_ellipse(40, 1);

    base = pending_items.size();
    while (pending_items.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: lone step, or a start that is dropped right away
        if (pick < 4) add_step();
        else add_item(FUNC_START, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(1, 1023), $urandom_range(1, 1023));
      end else if (pick < 22) begin
        // full-range radii, only a few iterations before the next start
        add_item(FUNC_START, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 1023), $urandom_range(1, 1023));
        walk_ellipse($urandom_range(1, 12), 0);
      end else begin
        // small radii walked to the end; a flat one makes region two clamp y
        ra = $urandom_range(1, 24);
        rb = (pick < 35) ? 1 : $urandom_range(1, 24);
        add_item(FUNC_START, $urandom_range(0, 4095), $urandom_range(0, 4095), ra, rb);
        walk_ellipse(60, $urandom_range(0, 2));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_midpoint_ellipse_rasterizer: done, clean");
    end else begin
      $display("tb_midpoint_ellipse_rasterizer: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mer_pkg.sv
rtl/core/mer_ctrl.sv
rtl/core/mer_dpath.sv
rtl/core/midpoint_ellipse_rasterizer.sv
dv/tb_midpoint_ellipse_rasterizer.sv
